// ===== hw/rtl/jpd_pkg.sv =====
// Shared constants, codes and word types for the joystick percent and direction block.
`default_nettype none

package jpd_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 8;
    localparam int CENTER_BITS = 8;
    localparam int DZ_BITS     = 7;
    localparam int PCT_BITS    = 8;
    localparam int MAG_BITS    = 7;
    localparam int DIR_BITS    = 3;

    // Divider: numerator is (sample distance * 100), one quotient bit per cycle
    localparam int NUM_BITS = SAMPLE_BITS + 7;
    localparam int CNT_BITS = $clog2(NUM_BITS);

    // Configuration port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = 2;

    localparam logic [IDX_BITS-1:0] REG_X_CENTER = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_Y_CENTER = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_DEADZONE = 2'd2;

    // Reset values
    localparam logic [SAMPLE_BITS-1:0] HIGH_RESET     = SAMPLE_BITS'(240);
    localparam logic [SAMPLE_BITS-1:0] LOW_RESET      = SAMPLE_BITS'(70);
    localparam logic [CENTER_BITS-1:0] CENTER_RESET   = 8'd128;
    localparam logic [DZ_BITS-1:0]     DEADZONE_RESET = 7'd20;
    localparam logic [MAG_BITS-1:0]    PERCENT_FULL   = 7'd100;

    // Direction codes
    localparam logic [DIR_BITS-1:0] DIR_CENTER = 3'd0;
    localparam logic [DIR_BITS-1:0] DIR_RIGHT  = 3'd1;
    localparam logic [DIR_BITS-1:0] DIR_LEFT   = 3'd2;
    localparam logic [DIR_BITS-1:0] DIR_UP     = 3'd3;
    localparam logic [DIR_BITS-1:0] DIR_DOWN   = 3'd4;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_sample;
        logic [SAMPLE_BITS-1:0] y_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [PCT_BITS-1:0] x_percent;
        logic signed [PCT_BITS-1:0] y_percent;
        logic [DIR_BITS-1:0]        direction;
    } out_word_t;

    // Sequencer controls for each axis unit
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } axis_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jpd_axis.sv =====
// One axis: extreme tracking, span selection and a bit-serial restoring divider.
`default_nettype none

module jpd_axis
    import jpd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire axis_ctrl_t             ctrl,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [CENTER_BITS-1:0] center,
    output logic [MAG_BITS-1:0]         mag,
    output logic                        neg
);

    logic [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic [SAMPLE_BITS-1:0] span_reg, span_next;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0]    num_reg, num_next;
    logic                   neg_reg;

    logic [SAMPLE_BITS-1:0] cen;
    logic [SAMPLE_BITS-1:0] delta;
    logic [NUM_BITS-1:0]    delta_w;
    logic                   above;
    logic                   below;
    logic [SAMPLE_BITS:0]   trial;
    logic                   fits;

    // Widen extremes with the incoming sample
    always_comb begin
        hi_next = (sample > hi_reg) ? sample : hi_reg;
        lo_next = (({1'b0, sample} + 1'b1) < {1'b0, lo_reg}) ? sample : lo_reg;
    end

    // Distance from center, span toward the active extreme, numerator = delta * 100
    always_comb begin
        cen   = SAMPLE_BITS'(center);
        above = samp_reg > cen;
        below = samp_reg < cen;
        if (above) begin
            delta     = samp_reg - cen;
            span_next = (hi_reg > cen) ? (hi_reg - cen) : SAMPLE_BITS'(1);
        end else begin
            delta     = below ? (cen - samp_reg) : '0;
            span_next = (cen > lo_reg) ? (cen - lo_reg) : SAMPLE_BITS'(1);
        end
        delta_w  = NUM_BITS'(delta);
        num_next = (delta_w << 6) + (delta_w << 5) + (delta_w << 2);
    end

    // One restoring step: quotient bits shift in behind the numerator
    always_comb begin
        trial = {rem_reg, num_reg[NUM_BITS-1]};
        fits  = trial >= {1'b0, span_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= HIGH_RESET;
            lo_reg <= LOW_RESET;
        end else if (ctrl.load) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            samp_reg <= sample;
        end
        if (ctrl.prep) begin
            span_reg <= span_next;
            num_reg  <= num_next;
            rem_reg  <= '0;
            neg_reg  <= below;
        end else if (ctrl.step) begin
            rem_reg <= fits ? SAMPLE_BITS'(trial - {1'b0, span_reg}) : trial[SAMPLE_BITS-1:0];
            num_reg <= {num_reg[NUM_BITS-2:0], fits};
        end
    end

    // Clamp quotient magnitude to full scale
    assign mag = (num_reg > NUM_BITS'(PERCENT_FULL)) ? PERCENT_FULL : num_reg[MAG_BITS-1:0];
    assign neg = neg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_percent_direction_unit.sv =====
// Top level: handshake, configuration registers, sequencer and direction decode.
//
// Usage:
//   Input words (x_sample, y_sample) arrive on s_valid/s_ready/s_data; one
//   result word (x_percent, y_percent, direction) leaves on m_valid/m_ready/
//   m_data for every input word. Centers and deadzone sit behind an APB-style
//   port at byte addresses 0, 4 and 8; write them only while the block is idle.
//   Sequence: the extremes are widened at the accepting edge, then span and
//   numerator are formed, then restoring division runs over the NUM_BITS (15)
//   numerator bits with one quotient bit per cycle in each axis divider, and the
//   result is decoded into the output register. One word is in flight at a time:
//   no new word is taken until the previous result is in the output register.
//   s_ready is high while the sequencer is idle; the output register holds the
//   previous result meanwhile, so a new word may start while m_valid waits.
//   If the receiver stalls, the finished result waits in the sequencer until
//   the output register frees up, and no new word is taken until then.
//   Reset (aresetn low, synchronous) drops m_valid, sets centers to 128, the
//   deadzone to 20 and the tracked extremes to 240 (high) and 70 (low).
`default_nettype none

module joystick_percent_direction_unit
    import jpd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_word_t             s_data,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_word_t                 m_data,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [CENTER_BITS-1:0] x_center_reg;
    logic [CENTER_BITS-1:0] y_center_reg;
    logic [DZ_BITS-1:0]     deadzone_reg;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              out_reg;
    out_word_t              result;

    logic [IDX_BITS-1:0]    reg_idx;
    logic                   cfg_write;
    logic                   in_take;
    logic                   out_load;
    axis_ctrl_t             ctrl;
    logic [MAG_BITS-1:0]    x_mag, y_mag;
    logic                   x_neg, y_neg;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_center_reg <= CENTER_RESET;
            y_center_reg <= CENTER_RESET;
            deadzone_reg <= DEADZONE_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_X_CENTER: x_center_reg <= pwdata[CENTER_BITS-1:0];
                REG_Y_CENTER: y_center_reg <= pwdata[CENTER_BITS-1:0];
                REG_DEADZONE: deadzone_reg <= pwdata[DZ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_X_CENTER: prdata = DATA_BITS'(x_center_reg);
            REG_Y_CENTER: prdata = DATA_BITS'(y_center_reg);
            REG_DEADZONE: prdata = DATA_BITS'(deadzone_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequencer
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_take  = s_valid && s_ready;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.load  = in_take;
        ctrl.prep  = (state_reg == ST_PREP);
        ctrl.step  = (state_reg == ST_DIV);
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_DIV;
                cnt_next   = CNT_BITS'(NUM_BITS - 1);
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Axis units
    jpd_axis u_x_axis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .sample  (s_data.x_sample),
        .center  (x_center_reg),
        .mag     (x_mag),
        .neg     (x_neg)
    );

    jpd_axis u_y_axis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .sample  (s_data.y_sample),
        .center  (y_center_reg),
        .mag     (y_mag),
        .neg     (y_neg)
    );

    // Signed percents and direction: larger magnitude wins, ties go to y
    always_comb begin
        result.x_percent = x_neg ? (PCT_BITS'(0) - PCT_BITS'(x_mag)) : PCT_BITS'(x_mag);
        result.y_percent = y_neg ? (PCT_BITS'(0) - PCT_BITS'(y_mag)) : PCT_BITS'(y_mag);
        result.direction = DIR_CENTER;
        if (x_mag > y_mag) begin
            if (x_mag > deadzone_reg) begin
                result.direction = x_neg ? DIR_LEFT : DIR_RIGHT;
            end
        end else begin
            if (y_mag > deadzone_reg) begin
                result.direction = y_neg ? DIR_DOWN : DIR_UP;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== test/joystick_percent_direction_unit_tb.sv =====
// Self-checking testbench for the joystick percent and direction unit.
`default_nettype none

module joystick_percent_direction_unit_tb;
    import jpd_pkg::*;

    localparam int                  HALF_PERIOD  = 10;
    localparam int                  RESET_CYCLES = 6;
    localparam int                  DRAIN_CYCLES = 24;
    localparam int                  HOLD_CYCLES  = 300;
    localparam int                  CYCLE_LIMIT  = 500000;
    localparam logic [IDX_BITS-1:0] REG_SPARE    = 2'd3;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_word_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    out_word_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // Shadow copy of the block's registers and tracked extremes
    logic [CENTER_BITS-1:0] x_center_q;
    logic [CENTER_BITS-1:0] y_center_q;
    logic [DZ_BITS-1:0]     deadzone_q;
    logic [SAMPLE_BITS-1:0] x_high_q;
    logic [SAMPLE_BITS-1:0] x_low_q;
    logic [SAMPLE_BITS-1:0] y_high_q;
    logic [SAMPLE_BITS-1:0] y_low_q;

    out_word_t pending_results[$];
    int        fail_count   = 0;
    int        cycle_count  = 0;
    bit        quiet        = 1'b0;
    bit        hold_off_req = 1'b0;

    joystick_percent_direction_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Signed percent of one axis about its center, clamped to +/-100
    function automatic int axis_percent(int s, int c, int lo, int hi);
        int span;
        int mag;
        if (s > c) begin
            span = (hi > c) ? hi - c : 1;
            mag  = ((s - c) * 100) / span;
            if (mag > int'(PERCENT_FULL)) mag = int'(PERCENT_FULL);
            return mag;
        end else if (s < c) begin
            span = (c > lo) ? c - lo : 1;
            mag  = ((c - s) * 100) / span;
            if (mag > int'(PERCENT_FULL)) mag = int'(PERCENT_FULL);
            return -mag;
        end
        return 0;
    endfunction

    // Larger magnitude wins, ties go to y; the loser is never consulted
    function automatic logic [DIR_BITS-1:0] stick_direction(int xp, int yp, int dz);
        int xm;
        int ym;
        xm = (xp < 0) ? -xp : xp;
        ym = (yp < 0) ? -yp : yp;
        if (xm > ym) begin
            if (xp > dz) return DIR_RIGHT;
            if (xp < -dz) return DIR_LEFT;
        end else begin
            if (yp > dz) return DIR_UP;
            if (yp < -dz) return DIR_DOWN;
        end
        return DIR_CENTER;
    endfunction

    // Widen the extremes, then scale both axes and decode the direction
    function automatic out_word_t predict_joystick(in_word_t w);
        out_word_t r;
        int        xp;
        int        yp;
        if (w.x_sample > x_high_q) x_high_q = w.x_sample;
        if (int'(w.x_sample) + 1 < int'(x_low_q)) x_low_q = w.x_sample;
        if (w.y_sample > y_high_q) y_high_q = w.y_sample;
        if (int'(w.y_sample) + 1 < int'(y_low_q)) y_low_q = w.y_sample;
        xp = axis_percent(int'(w.x_sample), int'(x_center_q), int'(x_low_q), int'(x_high_q));
        yp = axis_percent(int'(w.y_sample), int'(y_center_q), int'(y_low_q), int'(y_high_q));
        r.x_percent = PCT_BITS'(xp);
        r.y_percent = PCT_BITS'(yp);
        r.direction = stick_direction(xp, yp, int'(deadzone_q));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one word and hold it until accepted; valid stays high on return
    task automatic send_word(input logic [SAMPLE_BITS-1:0] xs,
                             input logic [SAMPLE_BITS-1:0] ys);
        in_word_t w;
        w.x_sample = xs;
        w.y_sample = ys;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_joystick(w));
    endtask

    task automatic pause_input(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Wait until every expected word is out and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, access cycle; register updates on the access edge
    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int unsigned val,
                             input bit noisy);
        logic [DATA_BITS-1:0] data;
        data = val;
        if (noisy)
            data = data | ($urandom() << ((idx == REG_DEADZONE) ? DZ_BITS : CENTER_BITS));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_X_CENTER: x_center_q = data[CENTER_BITS-1:0];
            REG_Y_CENTER: y_center_q = data[CENTER_BITS-1:0];
            REG_DEADZONE: deadzone_q = data[DZ_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int xc, input int yc, input int dz);
        write_reg(REG_X_CENTER, xc, 1'($urandom_range(0, 1)));
        write_reg(REG_Y_CENTER, yc, 1'($urandom_range(0, 1)));
        write_reg(REG_DEADZONE, dz, 1'($urandom_range(0, 1)));
    endtask

    // Mostly random, with a share near the center, at the rails and on center
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(int c);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            v = $urandom_range(0, 255);
        end else if (r < 8) begin
            v = c + $urandom_range(0, 60) - 30;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
        end else if (r == 8) begin
            v = $urandom_range(0, 1) ? 255 : 0;
        end else begin
            v = c;
        end
        return SAMPLE_BITS'(v);
    endfunction

    // Result channel: random stall bursts, or one long hold-off on request
    initial begin : ready_driver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %0d %0d %0d",
                       m_data.x_percent, m_data.y_percent, m_data.direction);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.x_percent !== want.x_percent) begin
                    $error("x_percent: expected %0d, got %0d", want.x_percent, m_data.x_percent);
                    fail_count++;
                end
                if (m_data.y_percent !== want.y_percent) begin
                    $error("y_percent: expected %0d, got %0d", want.y_percent, m_data.y_percent);
                    fail_count++;
                end
                if (m_data.direction !== want.direction) begin
                    $error("direction: expected %0d, got %0d", want.direction, m_data.direction);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lowest is not lowered by a sample one below it, so the clamp catches it
    task automatic test_one_below_lowest();
        send_word(8'd69, 8'd128);
        send_word(8'd128, 8'd69);
        drain();
    endtask

    // Center equal to lowest leaves no span below the center
    task automatic test_divisor_floor();
        set_config(70, 70, 20);
        send_word(8'd69, 8'd69);
        send_word(8'd70, 8'd70);
        send_word(8'd68, 8'd70);
        drain();
        set_config(128, 128, 20);
    endtask

    task automatic test_field_extremes();
        send_word(8'd255, 8'd0);
        send_word(8'd0, 8'd255);
        send_word(8'd255, 8'd255);
        send_word(8'd0, 8'd0);
        send_word(8'd128, 8'd128);
        drain();
    endtask

    task automatic test_deadzone();
        write_reg(REG_DEADZONE, 0, 1'b0);
        send_word(8'd130, 8'd128);
        send_word(8'd128, 8'd126);
        send_word(8'd130, 8'd126);
        send_word(8'd128, 8'd128);
        drain();
        write_reg(REG_DEADZONE, 100, 1'b1);
        send_word(8'd255, 8'd128);
        send_word(8'd128, 8'd0);
        drain();
        write_reg(REG_DEADZONE, 127, 1'b0);
        send_word(8'd0, 8'd0);
        send_word(8'd255, 8'd10);
        drain();
        write_reg(REG_DEADZONE, 20, 1'b0);
        // dominant axis just inside or just outside the deadzone, the other one inside
        send_word(8'd150, 8'd140);
        send_word(8'd160, 8'd150);
        send_word(8'd100, 8'd128);
        drain();
    endtask

    // Writes past the last register are dropped
    task automatic test_spare_register();
        write_reg(REG_SPARE, $urandom(), 1'b1);
        send_word(8'd200, 8'd60);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (8) send_word(SAMPLE_BITS'($urandom_range(0, 255)),
                             SAMPLE_BITS'($urandom_range(0, 255)));
        while (hold_off_req) @(posedge aclk);
        drain();
    endtask

    task automatic test_random_phase(input int xc, input int yc, input int dz,
                                     input int n_words, input int gap_odds);
        set_config(xc, yc, dz);
        for (int i = 0; i < n_words; i++) begin
            if (!quiet && gap_odds > 0 && $urandom_range(1, gap_odds) == 1)
                pause_input($urandom_range(1, 10));
            send_word(pick_sample(int'(x_center_q)), pick_sample(int'(y_center_q)));
        end
        drain();
    endtask

    initial begin
        x_center_q = CENTER_RESET;
        y_center_q = CENTER_RESET;
        deadzone_q = DEADZONE_RESET;
        x_high_q   = HIGH_RESET;
        x_low_q    = LOW_RESET;
        y_high_q   = HIGH_RESET;
        y_low_q    = LOW_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part; extremes are still at reset as the first two begin
        test_one_below_lowest();
        test_divisor_floor();
        test_field_extremes();
        test_deadzone();
        test_spare_register();
        test_backpressure();

        // random part over several settings, extremes included
        test_random_phase(128, 128, 20, 200, 4);
        test_random_phase(0, 255, 0, 180, 2);
        test_random_phase(255, 0, 100, 180, 6);
        test_random_phase($urandom_range(0, 255), $urandom_range(0, 255), 127, 150, 3);
        test_random_phase($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 127), 200, 4);

        // closing stretch with no idling on either side
        quiet = 1'b1;
        test_random_phase($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 100), 210, 0);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
